[hw/rtl/lnsig_pkg.sv]
package lnsig_pkg;

	// counters are 4 bits wide, so no dimension can reach past 16
	localparam int MAX_DIM     = 16;
	localparam int DIM_LIM     = (MAX_DIM < 16) ? MAX_DIM : 16;
	localparam int NUM_DIMS    = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 5;
	localparam int INDEX_W     = 16;

	typedef logic [3:0] coord_t;
	typedef logic [4:0] size_t;
	typedef logic [1:0] dim_t;
	typedef logic [8:0] inner_prod_t;
	typedef logic [7:0] scaled_coord_t;

	localparam dim_t DIM_K = 2'd0;
	localparam dim_t DIM_B = 2'd1;
	localparam dim_t DIM_H = 2'd2;
	localparam dim_t DIM_W = 2'd3;

	localparam size_t SIZE_LIM = size_t'(DIM_LIM);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_K       = 3'd0,
		REG_SIZE_B       = 3'd1,
		REG_SIZE_H       = 3'd2,
		REG_SIZE_W       = 3'd3,
		REG_ORDER_FIRST  = 3'd4,
		REG_ORDER_SECOND = 3'd5,
		REG_ORDER_THIRD  = 3'd6,
		REG_ORDER_LAST   = 3'd7
	} reg_idx_t;

	// which stride a dimension ends up with
	typedef enum logic [1:0] {
		STR_UNIT  = 2'd0,
		STR_LAST  = 2'd1,
		STR_INNER = 2'd2
	} stride_sel_t;

	function automatic size_t eff_size(input size_t v);
		size_t r;
		if (v == '0) begin
			r = size_t'(1);
		end else if (v > SIZE_LIM) begin
			r = SIZE_LIM;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[hw/rtl/loop_nest_strided_index_generator_unit.sv]
// Four-deep loop nest address generator (K outermost, W innermost). Every
// request word returns the current point's coordinates, its linear index
// (sum of stride times coordinate, kept to 16 bits) and a flag on the last
// point, then steps the counters, wrapping back to the origin after the last
// point; restart puts the counters at the origin first. Strides are
// mixed-radix products of the sizes in the programmed dimension order, the
// dimension named last getting stride 1; an order naming a dimension twice
// keeps the stride from the earlier-listed (outer) slot. Sizes of 0 count as
// 1 and sizes above 16 as 16. The block takes one word per clock while
// out_stall is low, through a two-stage pipeline; the first stage steps
// the counters and forms the partial products, the second the four stride
// multiplies and their sum. Configuration writes take effect on the next
// request word.
module loop_nest_strided_index_generator_unit
	import lnsig_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [INDEX_W-1:0]    point_index,
	output logic [3:0]            coord_k,
	output logic [3:0]            coord_b,
	output logic [3:0]            coord_h,
	output logic [3:0]            coord_w,
	output logic                  final_point
);

	size_t  size_q  [NUM_DIMS];
	dim_t   order_q [NUM_DIMS];
	coord_t count_q [NUM_DIMS];

	size_t         sz       [NUM_DIMS];
	coord_t        cur      [NUM_DIMS];
	coord_t        nxt      [NUM_DIMS];
	logic          wrap     [NUM_DIMS];
	scaled_coord_t scaled   [NUM_DIMS];
	stride_sel_t   sel      [NUM_DIMS];
	logic          fin;
	inner_prod_t   inner_prod;
	size_t         last_sz;

	logic          valid_s1;
	coord_t        coord_s1 [NUM_DIMS];
	logic          fin_s1;
	size_t         last_sz_s1;
	inner_prod_t   inner_s1;
	scaled_coord_t scaled_s1 [NUM_DIMS];
	stride_sel_t   sel_s1    [NUM_DIMS];

	logic               valid_s2;
	logic [INDEX_W-1:0] index_s2;
	coord_t             coord_s2 [NUM_DIMS];
	logic               fin_s2;

	logic               in_accept;
	logic               load_s2;
	logic [INDEX_W-1:0] term [NUM_DIMS];
	logic [INDEX_W-1:0] index_sum;

	assign load_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !load_s2;
	assign in_accept = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				size_q[i]  <= size_t'(1);
				order_q[i] <= dim_t'(i);
			end
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index)) inside
				REG_SIZE_K, REG_SIZE_B, REG_SIZE_H, REG_SIZE_W: begin
					size_q[cfg_index[1:0]] <= cfg_data;
				end
				REG_ORDER_FIRST, REG_ORDER_SECOND, REG_ORDER_THIRD, REG_ORDER_LAST: begin
					order_q[cfg_index[1:0]] <= cfg_data[1:0];
				end
			endcase
		end
	end

	// counter step, stride selection and partial products
	always_comb begin
		logic carry;
		carry = 1'b1;
		fin   = 1'b1;
		for (int d = 0; d < NUM_DIMS; d++) begin
			sz[d]  = eff_size(size_q[d]);
			cur[d] = restart ? '0 : count_q[d];
		end
		// w is the fastest digit, carry ripples toward k
		for (int d = NUM_DIMS - 1; d >= 0; d--) begin
			wrap[d] = ({1'b0, cur[d]} + 5'd1) >= sz[d];
			fin     = fin && wrap[d];
			if (carry) begin
				nxt[d] = wrap[d] ? '0 : cur[d] + 4'd1;
			end else begin
				nxt[d] = cur[d];
			end
			carry = carry && wrap[d];
		end
		last_sz    = sz[order_q[3]];
		inner_prod = inner_prod_t'(sz[order_q[3]]) * inner_prod_t'(sz[order_q[2]]);
		for (int d = 0; d < NUM_DIMS; d++) begin
			if (dim_t'(d) == order_q[0]) begin
				// outermost stride is inner_prod times the second size
				scaled[d] = scaled_coord_t'(sz[order_q[1]]) * scaled_coord_t'(cur[d]);
				sel[d]    = STR_INNER;
			end else if (dim_t'(d) == order_q[1]) begin
				scaled[d] = scaled_coord_t'(cur[d]);
				sel[d]    = STR_INNER;
			end else if (dim_t'(d) == order_q[2]) begin
				scaled[d] = scaled_coord_t'(cur[d]);
				sel[d]    = STR_LAST;
			end else begin
				scaled[d] = scaled_coord_t'(cur[d]);
				sel[d]    = STR_UNIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				count_q[i] <= '0;
			end
			valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				for (int i = 0; i < NUM_DIMS; i++) begin
					count_q[i] <= nxt[i];
				end
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			for (int i = 0; i < NUM_DIMS; i++) begin
				coord_s1[i]  <= cur[i];
				scaled_s1[i] <= scaled[i];
				sel_s1[i]    <= sel[i];
			end
			fin_s1     <= fin;
			last_sz_s1 <= last_sz;
			inner_s1   <= inner_prod;
		end
	end

	// stride multiplies and sum
	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			case (sel_s1[d])
				STR_INNER: term[d] = INDEX_W'(inner_s1) * INDEX_W'(scaled_s1[d]);
				STR_LAST:  term[d] = INDEX_W'(last_sz_s1) * INDEX_W'(scaled_s1[d]);
				default:   term[d] = INDEX_W'(scaled_s1[d]);
			endcase
		end
		index_sum = term[DIM_K] + term[DIM_B] + term[DIM_H] + term[DIM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			index_s2 <= index_sum;
			for (int i = 0; i < NUM_DIMS; i++) begin
				coord_s2[i] <= coord_s1[i];
			end
			fin_s2 <= fin_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign point_index = index_s2;
	assign coord_k     = coord_s2[DIM_K];
	assign coord_b     = coord_s2[DIM_B];
	assign coord_h     = coord_s2[DIM_H];
	assign coord_w     = coord_s2[DIM_W];
	assign final_point = fin_s2;

endmodule
